FILE: rtl/olisd_pkg.sv
// Shared types and constants for the ordered list insert/search/delete block.
package olisd_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // shared read port of the value and link memories
  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_rd_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
  } val_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
  } lnk_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_TAIL,
    S_WALK,
    S_DONE
  } state_t;

endpackage

FILE: rtl/olisd_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module olisd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/olisd_ctrl.sv
// Sequencer: free slot scan, list walk and link updates for one transaction.
module olisd_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  olisd_pkg::req_t                   req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output olisd_pkg::rsp_t                   res,
  output olisd_pkg::mem_rd_t                mem_rd,
  output olisd_pkg::val_wr_t                val_wr,
  output olisd_pkg::lnk_wr_t                lnk_wr,
  input  logic [olisd_pkg::VALUE_W-1:0]     val_rdata,
  input  logic [olisd_pkg::SLOT_W-1:0]      lnk_rdata
);

  olisd_pkg::state_t state, state_next;

  olisd_pkg::req_t                  req_q, req_q_next;
  logic [olisd_pkg::CAPACITY-1:0]   free_map, free_map_next;
  logic [olisd_pkg::SLOT_W-1:0]     head, head_next;
  logic [olisd_pkg::SLOT_W-1:0]     tail, tail_next;
  logic [olisd_pkg::CNT_W-1:0]      count, count_next;
  logic [olisd_pkg::SLOT_W-1:0]     cur, cur_next;
  logic [olisd_pkg::SLOT_W-1:0]     prev, prev_next;
  logic [olisd_pkg::SLOT_W-1:0]     pos, pos_next;
  logic [olisd_pkg::SLOT_W-1:0]     slot, slot_next;
  olisd_pkg::status_t               res_status, res_status_next;
  logic                             res_found, res_found_next;
  logic [olisd_pkg::SLOT_W-1:0]     res_pos, res_pos_next;

  logic match;
  logic last;

  assign match = val_rdata == req_q.value;
  assign last  = (olisd_pkg::CNT_W'(pos) + olisd_pkg::CNT_W'(1)) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= olisd_pkg::S_IDLE;
      free_map <= '1;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else begin
      state    <= state_next;
      free_map <= free_map_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    cur        <= cur_next;
    prev       <= prev_next;
    pos        <= pos_next;
    slot       <= slot_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_pos    <= res_pos_next;
  end

  always_comb begin
    state_next      = state;
    req_q_next      = req_q;
    free_map_next   = free_map;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    cur_next        = cur;
    prev_next       = prev;
    pos_next        = pos;
    slot_next       = slot;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_pos_next    = res_pos;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    mem_rd          = '0;
    val_wr          = '0;
    lnk_wr          = '0;

    case (state)
      olisd_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_q_next      = req;
          res_status_next = olisd_pkg::ST_OK;
          res_found_next  = 1'b0;
          res_pos_next    = '0;
          case (req.action)
            olisd_pkg::ACT_INSERT: begin
              if (count == olisd_pkg::CNT_W'(olisd_pkg::CAPACITY)) begin
                res_status_next = olisd_pkg::ST_FULL;
                state_next      = olisd_pkg::S_DONE;
              end else begin
                slot_next  = '0;
                state_next = olisd_pkg::S_INS_SCAN;
              end
            end
            olisd_pkg::ACT_SEARCH, olisd_pkg::ACT_DELETE: begin
              if (count == '0) begin
                res_status_next = olisd_pkg::ST_EMPTY;
                state_next      = olisd_pkg::S_DONE;
              end else begin
                cur_next     = head;
                prev_next    = tail;
                pos_next     = '0;
                mem_rd.re    = 1'b1;
                mem_rd.raddr = head;
                state_next   = olisd_pkg::S_WALK;
              end
            end
            default: begin
              state_next = olisd_pkg::S_DONE;
            end
          endcase
        end
      end

      olisd_pkg::S_INS_SCAN: begin
        if (free_map[slot]) begin
          free_map_next[slot] = 1'b0;
          val_wr.we           = 1'b1;
          val_wr.waddr        = slot;
          val_wr.wdata        = req_q.value;
          lnk_wr.we           = 1'b1;
          lnk_wr.waddr        = slot;
          if (count == '0) begin
            lnk_wr.wdata = slot;
            head_next    = slot;
            tail_next    = slot;
            count_next   = count + olisd_pkg::CNT_W'(1);
            state_next   = olisd_pkg::S_DONE;
          end else begin
            lnk_wr.wdata = head;
            state_next   = olisd_pkg::S_INS_TAIL;
          end
        end else begin
          slot_next = slot + olisd_pkg::SLOT_W'(1);
        end
      end

      olisd_pkg::S_INS_TAIL: begin
        lnk_wr.we    = 1'b1;
        lnk_wr.waddr = tail;
        lnk_wr.wdata = slot;
        tail_next    = slot;
        count_next   = count + olisd_pkg::CNT_W'(1);
        state_next   = olisd_pkg::S_DONE;
      end

      olisd_pkg::S_WALK: begin
        if (match) begin
          res_found_next = 1'b1;
          res_pos_next   = pos;
          state_next     = olisd_pkg::S_DONE;
          if (req_q.action == olisd_pkg::ACT_DELETE) begin
            free_map_next[cur] = 1'b1;
            if (count == olisd_pkg::CNT_W'(1)) begin
              count_next = '0;
            end else begin
              lnk_wr.we    = 1'b1;
              lnk_wr.waddr = prev;
              lnk_wr.wdata = lnk_rdata;
              if (pos == '0) begin
                head_next = lnk_rdata;
              end
              if (cur == tail) begin
                tail_next = prev;
              end
              count_next = count - olisd_pkg::CNT_W'(1);
            end
          end
        end else if (last) begin
          res_status_next = olisd_pkg::ST_NOT_FOUND;
          state_next      = olisd_pkg::S_DONE;
        end else begin
          prev_next    = cur;
          cur_next     = lnk_rdata;
          pos_next     = pos + olisd_pkg::SLOT_W'(1);
          mem_rd.re    = 1'b1;
          mem_rd.raddr = lnk_rdata;
        end
      end

      olisd_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = olisd_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = olisd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = res_status;
    res.found       = res_found;
    res.position    = olisd_pkg::POS_W'(res_pos);
    res.entry_count = olisd_pkg::COUNT_W'(count);
  end

endmodule

FILE: rtl/ordered_list_insert_search_delete_top.sv
// Top level of the ordered list block: slot memories, sequencer and result register.
//
// Holds up to 64 signed 32-bit values as a circular linked list in two
// slot memories with registered reads (values and next links); a free-slot
// bitmap in flops is set to all free by reset, so no clearing pass is
// needed. One transaction is worked on at a time. Search and delete walk
// the list from the head, one memory read per cycle. Insert scans the free
// bitmap one slot per cycle. Full, empty and unused action codes go to the
// result without a scan or walk. The next request is taken while a result
// still waits in the output register.
module ordered_list_insert_search_delete_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  olisd_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output olisd_pkg::rsp_t rsp
);

  olisd_pkg::mem_rd_t             mem_rd;
  olisd_pkg::val_wr_t             val_wr;
  olisd_pkg::lnk_wr_t             lnk_wr;
  logic [olisd_pkg::VALUE_W-1:0]  val_rdata;
  logic [olisd_pkg::SLOT_W-1:0]   lnk_rdata;
  logic                           res_valid;
  logic                           res_ready;
  olisd_pkg::rsp_t                res;

  olisd_ram #(
    .WIDTH (olisd_pkg::VALUE_W),
    .DEPTH (olisd_pkg::CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_wr.we),
    .waddr (val_wr.waddr),
    .wdata (val_wr.wdata),
    .re    (mem_rd.re),
    .raddr (mem_rd.raddr),
    .rdata (val_rdata)
  );

  olisd_ram #(
    .WIDTH (olisd_pkg::SLOT_W),
    .DEPTH (olisd_pkg::CAPACITY)
  ) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_wr.we),
    .waddr (lnk_wr.waddr),
    .wdata (lnk_wr.wdata),
    .re    (mem_rd.re),
    .raddr (mem_rd.raddr),
    .rdata (lnk_rdata)
  );

  olisd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_rd    (mem_rd),
    .val_wr    (val_wr),
    .lnk_wr    (lnk_wr),
    .val_rdata (val_rdata),
    .lnk_rdata (lnk_rdata)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
